FILE: hdl/gtc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and an arithmetic helper of the grid colouring counter.
package gtc_pkg;

  localparam int ROWS_W        = 3;
  localparam int COLS_W        = 11;
  localparam int WAYS_W        = 30;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 32;
  localparam int DIGIT_W       = 2;
  localparam int MAX_ROWS_DEF    = 5;
  localparam int MAX_COLUMNS_DEF = 1024;

  localparam logic [DIGIT_W-1:0] DIGIT_TOP = 2'd2;
  localparam logic [WAYS_W-1:0]  WAYS_MOD  = 30'd1000000007;
  localparam logic [WAYS_W-1:0]  WAYS_ONE  = 30'd1;

  // Status of the pattern generator for the current candidate.
  typedef struct packed {
    logic hit;   // candidate has no equal vertical neighbours
    logic last;  // candidate is the final one for this row count
  } gtc_gen_stat_t;

  // Addition of two residues modulo WAYS_MOD.
  function automatic logic [WAYS_W-1:0] mod_add(input logic [WAYS_W-1:0] a,
                                                 input logic [WAYS_W-1:0] b);
    logic [WAYS_W:0] sum;
    logic [WAYS_W:0] red;
    sum = {1'b0, a} + {1'b0, b};
    red = sum - {1'b0, WAYS_MOD};
    if (sum >= {1'b0, WAYS_MOD}) begin
      return red[WAYS_W-1:0];
    end
    return sum[WAYS_W-1:0];
  endfunction

endpackage

FILE: hdl/grid_three_coloring_counter.sv
`timescale 1ns / 1ps
// Flow: with P = 3 * 2^(rows-1) valid patterns, a word is handled by listing all 3^rows
//   candidates, seeding P entries of the first column, building each later column entry by
//   entry from all P entries of the previous one, and summing the final column.
// Throughput: one word at a time; in_tready is high only while the block is idle.
// Reset: rst_n is synchronous and active low; it clears control state only.
//   The RAMs are not cleared: every entry is written within a word before it is read.
module grid_three_coloring_counter import gtc_pkg::*; #(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [2:0] rows, [13:3] columns, [15:14] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [29:0] ways, [31:30] zero
);

  // Sizing that follows from the parameters.
  localparam int PatDepth = 3 << (MAX_ROWS - 1);
  localparam int IdxW     = $clog2(PatDepth);
  localparam int CntW     = $clog2(PatDepth + 1);
  localparam int PatW     = DIGIT_W * MAX_ROWS;
  localparam int ColW     = $clog2(MAX_COLUMNS + 1);
  localparam int WaysDepth = 1 << (IdxW + 1);

  // Sequencer states. GEN lists the valid patterns, INIT seeds the first
  // column with ones, FETCH/ACC build one entry of the next column vector,
  // SUM totals the final vector and FIN hands the total to the output register.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_GEN   = 7'b0000010,
    S_INIT  = 7'b0000100,
    S_FETCH = 7'b0001000,
    S_ACC   = 7'b0010000,
    S_SUM   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [ROWS_W-1:0] rows_r, rows_nxt;
  logic [ColW-1:0]   cols_r, cols_nxt;
  logic [ColW-1:0]   col_r, col_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [CntW-1:0]   i_r, i_nxt;
  logic [CntW-1:0]   j_r, j_nxt;
  logic              bank_r, bank_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              pi_load_r, pi_load_nxt;
  logic [PatW-1:0]   pi_r, pi_nxt;
  logic [WAYS_W-1:0] acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WAYS_W-1:0] out_data_r, out_data_nxt;

  // Input word fields and their clamped forms.
  logic [ROWS_W-1:0] in_rows;
  logic [COLS_W-1:0] in_cols;
  logic [ROWS_W-1:0] rows_sat;
  logic [ColW-1:0]   cols_sat;

  assign in_rows = in_tdata[ROWS_W-1:0];
  assign in_cols = in_tdata[ROWS_W +: COLS_W];

  always_comb begin
    if (in_rows == '0) begin
      rows_sat = ROWS_W'(1);
    end else if (int'(in_rows) > MAX_ROWS) begin
      rows_sat = ROWS_W'(MAX_ROWS);
    end else begin
      rows_sat = in_rows;
    end
    if (in_cols == '0) begin
      cols_sat = ColW'(1);
    end else if (int'(in_cols) > MAX_COLUMNS) begin
      cols_sat = ColW'(MAX_COLUMNS);
    end else begin
      cols_sat = ColW'(in_cols);
    end
  end

  // Pattern generator.
  logic          gen_start;
  logic          gen_step;
  logic [PatW-1:0] gen_pat;
  gtc_gen_stat_t gen_stat;

  gtc_patgen #(
    .MAX_ROWS (MAX_ROWS)
  ) u_patgen (
    .clk   (clk),
    .start (gen_start),
    .step  (gen_step),
    .rows  (rows_r),
    .pat   (gen_pat),
    .stat  (gen_stat)
  );

  // Pattern list RAM: one two-bit code per row, written while listing.
  logic            pat_we;
  logic [IdxW-1:0] pat_raddr;
  logic [PatW-1:0] pat_rdata;

  gtc_ram #(
    .WIDTH (PatW),
    .DEPTH (PatDepth)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (cnt_r[IdxW-1:0]),
    .wdata (gen_pat),
    .raddr (pat_raddr),
    .rdata (pat_rdata)
  );

  // Ways RAM: two banks of count vectors, selected by the top address bit.
  // A column reads the bank in bank_r and writes the other, so a read and a
  // write never meet on the same entry.
  logic              ways_we;
  logic [IdxW:0]     ways_waddr;
  logic [WAYS_W-1:0] ways_wdata;
  logic [IdxW:0]     ways_raddr;
  logic [WAYS_W-1:0] ways_rdata;

  gtc_ram #(
    .WIDTH (WAYS_W),
    .DEPTH (WaysDepth)
  ) u_ways_ram (
    .clk   (clk),
    .we    (ways_we),
    .waddr (ways_waddr),
    .wdata (ways_wdata),
    .raddr (ways_raddr),
    .rdata (ways_rdata)
  );

  // Two patterns are compatible when they differ in every used row.
  logic compat;

  always_comb begin
    compat = 1'b1;
    for (int k = 0; k < MAX_ROWS; k++) begin
      if (k < int'(rows_r) &&
          pi_r[DIGIT_W*k +: DIGIT_W] == pat_rdata[DIGIT_W*k +: DIGIT_W]) begin
        compat = 1'b0;
      end
    end
  end

  // A read is issued each cycle while j has not reached the pattern count;
  // its data arrives in the following cycle and is marked by rd_vld_r.
  logic issuing;
  logic out_free;

  assign issuing  = (j_r != cnt_r);
  assign out_free = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign gen_start  = (state_r == S_IDLE) && in_tvalid;
  assign gen_step   = (state_r == S_GEN);
  assign pat_we     = (state_r == S_GEN) && gen_stat.hit;
  assign pat_raddr  = (state_r == S_FETCH) ? i_r[IdxW-1:0] : j_r[IdxW-1:0];
  assign ways_raddr = {bank_r, j_r[IdxW-1:0]};

  always_comb begin
    state_nxt     = state_r;
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    col_nxt       = col_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    bank_nxt      = bank_r;
    rd_vld_nxt    = 1'b0;
    pi_load_nxt   = 1'b0;
    pi_nxt        = pi_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ways_we       = 1'b0;
    ways_waddr    = {1'b0, j_r[IdxW-1:0]};
    ways_wdata    = WAYS_ONE;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          rows_nxt  = rows_sat;
          cols_nxt  = cols_sat;
          cnt_nxt   = '0;
          j_nxt     = '0;
          bank_nxt  = 1'b0;
          state_nxt = S_GEN;
        end
      end

      S_GEN: begin
        if (gen_stat.hit) begin
          cnt_nxt = cnt_r + CntW'(1);
        end
        if (gen_stat.last) begin
          state_nxt = S_INIT;
        end
      end

      // Every pattern starts with one way for the first column.
      S_INIT: begin
        ways_we = 1'b1;
        if (j_r + CntW'(1) == cnt_r) begin
          j_nxt   = '0;
          i_nxt   = '0;
          col_nxt = ColW'(1);
          acc_nxt = '0;
          if (cols_r == ColW'(1)) begin
            state_nxt = S_SUM;
          end else begin
            state_nxt = S_FETCH;
          end
        end else begin
          j_nxt = j_r + CntW'(1);
        end
      end

      S_FETCH: begin
        pi_load_nxt = 1'b1;
        j_nxt       = '0;
        acc_nxt     = '0;
        state_nxt   = S_ACC;
      end

      S_ACC: begin
        if (pi_load_r) begin
          pi_nxt = pat_rdata;
        end
        if (issuing) begin
          j_nxt      = j_r + CntW'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r && compat) begin
          acc_nxt = mod_add(acc_r, ways_rdata);
        end
        if (!issuing && !rd_vld_r) begin
          // Entry i of the new column is complete.
          ways_we    = 1'b1;
          ways_waddr = {!bank_r, i_r[IdxW-1:0]};
          ways_wdata = acc_r;
          acc_nxt    = '0;
          j_nxt      = '0;
          if (i_r + CntW'(1) == cnt_r) begin
            i_nxt    = '0;
            bank_nxt = !bank_r;
            if (col_r + ColW'(1) == cols_r) begin
              state_nxt = S_SUM;
            end else begin
              col_nxt   = col_r + ColW'(1);
              state_nxt = S_FETCH;
            end
          end else begin
            i_nxt     = i_r + CntW'(1);
            state_nxt = S_FETCH;
          end
        end
      end

      // Total of the final vector.
      S_SUM: begin
        if (issuing) begin
          j_nxt      = j_r + CntW'(1);
          rd_vld_nxt = 1'b1;
        end
        if (rd_vld_r) begin
          acc_nxt = mod_add(acc_r, ways_rdata);
        end
        if (!issuing && !rd_vld_r) begin
          state_nxt = S_FIN;
        end
      end

      // Wait for the output register to be free, then hand over the total.
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rows_r      <= '0;
      cols_r      <= '0;
      col_r       <= '0;
      cnt_r       <= '0;
      i_r         <= '0;
      j_r         <= '0;
      bank_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      pi_load_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      col_r       <= col_nxt;
      cnt_r       <= cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      bank_r      <= bank_nxt;
      rd_vld_r    <= rd_vld_nxt;
      pi_load_r   <= pi_load_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    pi_r       <= pi_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - WAYS_W){1'b0}}, out_data_r};

`ifndef SYNTHESIS
  // A column update never writes into the bank it is reading from.
  a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
    (ways_we && state_r == S_ACC) |-> (ways_waddr[IdxW] != ways_raddr[IdxW]))
    else $error("ways RAM write hits the bank being read");

  // Listing ends with exactly 3 * 2^(rows-1) valid patterns.
  a_pat_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GEN && gen_stat.last) |=>
      (int'(cnt_r) == (3 << (int'(rows_r) - 1))))
    else $error("pattern count does not match the row count");

  // A delivered total is always a reduced residue.
  a_out_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r < WAYS_MOD))
    else $error("result is not below the modulus");

  // The accumulator holds a reduced residue while a column entry is built.
  a_acc_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC && $past(state_r) == S_ACC) |-> (acc_r < WAYS_MOD))
    else $error("accumulator left the residue range");
`endif

endmodule

FILE: hdl/gtc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module gtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/gtc_patgen.sv
`timescale 1ns / 1ps
// Base-3 column pattern odometer with the no-equal-neighbours check.
module gtc_patgen import gtc_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          start,
  input  logic                          step,
  input  logic [ROWS_W-1:0]             rows,
  output logic [DIGIT_W*MAX_ROWS-1:0]   pat,
  output gtc_gen_stat_t                 stat
);

  localparam int PatW = DIGIT_W * MAX_ROWS;

  logic [PatW-1:0] pat_r;
  logic [PatW-1:0] pat_nxt;

  // Ripple increment, lowest digit first, each digit counting 0, 1, 2.
  always_comb begin
    logic carry;
    carry   = 1'b1;
    pat_nxt = pat_r;
    for (int k = 0; k < MAX_ROWS; k++) begin
      if (carry) begin
        if (pat_r[DIGIT_W*k +: DIGIT_W] == DIGIT_TOP) begin
          pat_nxt[DIGIT_W*k +: DIGIT_W] = '0;
        end else begin
          pat_nxt[DIGIT_W*k +: DIGIT_W] = pat_r[DIGIT_W*k +: DIGIT_W] + DIGIT_W'(1);
          carry = 1'b0;
        end
      end
    end
  end

  always_comb begin
    stat.hit  = 1'b1;
    stat.last = 1'b1;
    for (int k = 0; k < MAX_ROWS; k++) begin
      if (k < int'(rows) && pat_r[DIGIT_W*k +: DIGIT_W] != DIGIT_TOP) begin
        stat.last = 1'b0;
      end
    end
    for (int k = 1; k < MAX_ROWS; k++) begin
      if (k < int'(rows) &&
          pat_r[DIGIT_W*k +: DIGIT_W] == pat_r[DIGIT_W*(k-1) +: DIGIT_W]) begin
        stat.hit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pat_r <= '0;
    end else if (step) begin
      pat_r <= pat_nxt;
    end
  end

  assign pat = pat_r;

endmodule
